[hw/rtl/stlom_pkg.sv]
// Shared types and constants for the switch, relay and light output mapper.
`default_nettype none

package stlom_pkg;

    localparam int GANGS = 4;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    localparam logic [12:0] TEMP_MIN = 13'd2000;
    localparam logic [12:0] TEMP_MAX = 13'd6500;
    localparam logic [6:0]  PCT_MAX  = 7'd100;

    typedef enum logic [1:0] {
        CMD_TICK = 2'd0,
        CMD_EDGE = 2'd1,
        CMD_APP  = 2'd2
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GANGS_FITTED = 3'd0,
        CFG_DEBOUNCE     = 3'd1,
        CFG_LED_FITTED   = 3'd2,
        CFG_BRIGHTNESS   = 3'd3,
        CFG_COLOR_TEMP   = 3'd4,
        CFG_RED          = 3'd5,
        CFG_GREEN        = 3'd6,
        CFG_BLUE         = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [2:0] gangs_fitted;
        logic [7:0] debounce_ticks;
        logic       led_fitted;
        logic [6:0] bright_pct;
        logic       ct_on;
        logic [6:0] warm_share;
        logic [7:0] red_level;
        logic [7:0] green_level;
        logic [7:0] blue_level;
    } t_cfg;

    typedef struct packed {
        logic [3:0] relay_bits;
        logic       toggled;
    } t_ctrl;

    typedef struct packed {
        logic [9:0] dimmer_duty;
        logic [9:0] warm_duty;
        logic [9:0] cool_duty;
        logic [9:0] red_duty;
        logic [9:0] green_duty;
        logic [9:0] blue_duty;
    } t_duty;

endpackage

`default_nettype wire

[hw/rtl/stlom_cfg.sv]
// Configuration register file with clamped brightness and colour temperature blend.
`default_nettype none

module stlom_cfg (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [stlom_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [stlom_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    output stlom_pkg::t_cfg                         o_cfg
);
    import stlom_pkg::*;

    t_cfg        r_cfg;
    logic [12:0] n_temp;
    logic [12:0] n_span;
    logic [25:0] n_prod;
    logic [6:0]  n_warm_share;
    logic [6:0]  n_bright;

    // warm% = span / 45, by reciprocal 5826 / 2^18
    always_comb begin
        if (i_cfg_wdata < TEMP_MIN) begin
            n_temp = TEMP_MIN;
        end else if (i_cfg_wdata > TEMP_MAX) begin
            n_temp = TEMP_MAX;
        end else begin
            n_temp = i_cfg_wdata;
        end
        n_span       = TEMP_MAX - n_temp;
        n_prod       = 26'(n_span) * 26'd5826;
        n_warm_share = n_prod[24:18];
        n_bright     = (i_cfg_wdata[6:0] > PCT_MAX) ? PCT_MAX : i_cfg_wdata[6:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gangs_fitted   <= 3'd1;
            r_cfg.debounce_ticks <= 8'd50;
            r_cfg.led_fitted     <= 1'b1;
            r_cfg.bright_pct     <= 7'd0;
            r_cfg.ct_on          <= 1'b0;
            r_cfg.warm_share     <= PCT_MAX;
            r_cfg.red_level      <= 8'd0;
            r_cfg.green_level    <= 8'd0;
            r_cfg.blue_level     <= 8'd0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_GANGS_FITTED: r_cfg.gangs_fitted   <= i_cfg_wdata[2:0];
                CFG_DEBOUNCE:     r_cfg.debounce_ticks <= i_cfg_wdata[7:0];
                CFG_LED_FITTED:   r_cfg.led_fitted     <= i_cfg_wdata[0];
                CFG_BRIGHTNESS:   r_cfg.bright_pct     <= n_bright;
                CFG_COLOR_TEMP: begin
                    r_cfg.ct_on      <= (i_cfg_wdata != 13'd0);
                    r_cfg.warm_share <= n_warm_share;
                end
                CFG_RED:          r_cfg.red_level      <= i_cfg_wdata[7:0];
                CFG_GREEN:        r_cfg.green_level    <= i_cfg_wdata[7:0];
                CFG_BLUE:         r_cfg.blue_level     <= i_cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

[hw/rtl/stlom_ctrl.sv]
// Debounce lockout window and relay state.
`default_nettype none

module stlom_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_adv,
    input  wire logic [1:0]     i_cmd,
    input  wire logic [1:0]     i_gang,
    input  wire logic           i_value,
    input  wire stlom_pkg::t_cfg i_cfg,
    output stlom_pkg::t_ctrl    o_ctrl
);
    import stlom_pkg::*;

    logic [3:0] r_relay;
    logic       r_win_active;
    logic [7:0] r_win_left;
    logic [1:0] r_pending;

    logic [3:0] n_relay;
    logic       n_win_active;
    logic [7:0] n_win_left;
    logic [1:0] n_pending;
    logic       n_toggled;
    logic       gang_fitted;

    assign gang_fitted = ({1'b0, r_pending} < i_cfg.gangs_fitted) && (int'(r_pending) < GANGS);

    always_comb begin
        n_relay      = r_relay;
        n_win_active = r_win_active;
        n_win_left   = r_win_left;
        n_pending    = r_pending;
        n_toggled    = 1'b0;
        unique case (t_cmd'(i_cmd))
            CMD_TICK: begin
                if (r_win_active) begin
                    if (r_win_left <= 8'd1) begin
                        n_win_active = 1'b0;
                        n_win_left   = 8'd0;
                        if (gang_fitted) begin
                            n_relay   = r_relay ^ (4'd1 << r_pending);
                            n_toggled = 1'b1;
                        end
                    end else begin
                        n_win_left = r_win_left - 8'd1;
                    end
                end
            end
            CMD_EDGE: begin
                if (!r_win_active) begin
                    n_win_active = 1'b1;
                    n_win_left   = i_cfg.debounce_ticks;
                    n_pending    = i_gang;
                end
            end
            CMD_APP: begin
                n_relay = {r_relay[3:1], i_value};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_relay      <= 4'd0;
            r_win_active <= 1'b0;
            r_win_left   <= 8'd0;
            r_pending    <= 2'd0;
        end else if (i_adv) begin
            r_relay      <= n_relay;
            r_win_active <= n_win_active;
            r_win_left   <= n_win_left;
            r_pending    <= n_pending;
        end
    end

    assign o_ctrl.relay_bits = n_relay;
    assign o_ctrl.toggled    = n_toggled;

endmodule

`default_nettype wire

[hw/rtl/stlom_map.sv]
// PWM duty mapping for dimmer, white blend and RGB channels.
`default_nettype none

module stlom_map (
    input  wire logic            i_relay0,
    input  wire stlom_pkg::t_cfg i_cfg,
    output stlom_pkg::t_duty     o_duty
);
    import stlom_pkg::*;

    // pct*1023/100 = 10*pct + (23*pct)/100, the latter by reciprocal 2622 / 2^18
    function automatic logic [9:0] pct_to_duty(input logic [6:0] pct);
        logic [11:0] y;
        logic [23:0] prod;
        logic [9:0]  base;
        y    = 12'(pct) * 12'd23;
        prod = 24'(y) * 24'd2622;
        base = 10'({3'd0, pct} << 3) + 10'({3'd0, pct} << 1);
        return base + 10'(prod[22:18]);
    endfunction

    // v*1023/255 = 4*v + v/85
    function automatic logic [9:0] byte_to_duty(input logic [7:0] v);
        logic [1:0] q;
        if (v >= 8'd255) begin
            q = 2'd3;
        end else if (v >= 8'd170) begin
            q = 2'd2;
        end else if (v >= 8'd85) begin
            q = 2'd1;
        end else begin
            q = 2'd0;
        end
        return {v, 2'b00} + 10'(q);
    endfunction

    logic white_on;
    assign white_on = i_relay0 && i_cfg.ct_on;

    assign o_duty.dimmer_duty = i_relay0 ? pct_to_duty(i_cfg.bright_pct) : 10'd0;
    assign o_duty.warm_duty   = white_on ? pct_to_duty(i_cfg.warm_share) : 10'd0;
    assign o_duty.cool_duty   = white_on ? pct_to_duty(PCT_MAX - i_cfg.warm_share) : 10'd0;
    assign o_duty.red_duty    = i_relay0 ? byte_to_duty(i_cfg.red_level) : 10'd0;
    assign o_duty.green_duty  = i_relay0 ? byte_to_duty(i_cfg.green_level) : 10'd0;
    assign o_duty.blue_duty   = i_relay0 ? byte_to_duty(i_cfg.blue_level) : 10'd0;

endmodule

`default_nettype wire

[hw/rtl/switch_toggle_light_output_mapper_top.sv]
// Top level: input register, debounce control, duty mapping and result register.
//
//  channel   direction  payload
//  s_axis    in         tuser: command; tdata: gang, relay_value
//  m_axis    out        tdata: relay bits, LED, six duties, toggled
//  cfg       in         write enable, register index, write data
//
// One word per cycle sustained while m_axis is ready; a word is held in the input
// register and its result then sits in the result register.
// Relay state and the lockout window update as the word leaves the input register.
// A stall on m_axis holds the result; one more word waits in the input register.
// Synchronous active-low reset clears valids, relays and the window.
`default_nettype none

module switch_toggle_light_output_mapper_top (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic [7:0]                         s_axis_tdata,  // gang[1:0], relay_value[2]
    input  wire logic [1:0]                         s_axis_tuser,  // command[1:0]
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // relay_bits[3:0], status_led[4], dimmer[14:5], warm[24:15], cool[34:25],
    // red[44:35], green[54:45], blue[64:55], toggled[65]
    output logic [71:0]                             m_axis_tdata,
    input  wire logic                               i_cfg_we,
    input  wire logic [stlom_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [stlom_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);
    import stlom_pkg::*;

    logic        r_in_valid;
    logic [1:0]  r_in_cmd;
    logic [1:0]  r_in_gang;
    logic        r_in_value;
    logic        r_out_valid;
    logic [71:0] r_out_data;

    logic        in_adv;
    t_cfg        cfg;
    t_ctrl       ctrl;
    t_duty       duty;

    assign in_adv        = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || in_adv;

    stlom_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    stlom_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (in_adv),
        .i_cmd   (r_in_cmd),
        .i_gang  (r_in_gang),
        .i_value (r_in_value),
        .i_cfg   (cfg),
        .o_ctrl  (ctrl)
    );

    stlom_map u_map (
        .i_relay0 (ctrl.relay_bits[0]),
        .i_cfg    (cfg),
        .o_duty   (duty)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (in_adv) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_cmd   <= s_axis_tuser;
            r_in_gang  <= s_axis_tdata[1:0];
            r_in_value <= s_axis_tdata[2];
        end
        if (in_adv) begin
            r_out_data <= {6'd0, ctrl.toggled,
                           duty.blue_duty, duty.green_duty, duty.red_duty,
                           duty.cool_duty, duty.warm_duty, duty.dimmer_duty,
                           cfg.led_fitted & ctrl.relay_bits[0], ctrl.relay_bits};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

`default_nettype wire
